// ===== design/cht_pkg.sv =====
// Shared types and constants for the chained hash table.
`timescale 1ns / 1ps
package cht_pkg;
	localparam int MAX_BUCKETS = 64;
	localparam int WAYS        = 4;
	localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
	localparam int WAY_W       = $clog2(WAYS);
	localparam int KEY_W       = 31;
	localparam int VAL_W       = 32;
	localparam int CFG_W       = 7;
	localparam int OP_W        = 2;

	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
		logic [BUCKET_W-1:0]     bucket;
	} req_t;
endpackage

// ===== design/cht_front.sv =====
// Front end: accepts requests and computes the bucket by key modulo bucket count (0 read as 1, capped at MAX_BUCKETS).
`timescale 1ns / 1ps
module cht_front import cht_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [OP_W-1:0]         operation,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] value,
	input  logic [CFG_W-1:0]        bucket_count,
	output req_t                    q_req,
	output logic                    q_push,
	input  logic                    q_full
);
	localparam logic [1:0] FR_IDLE = 2'd0;
	localparam logic [1:0] FR_DIV  = 2'd1;
	localparam logic [1:0] FR_PUSH = 2'd2;
	localparam int STEP_BITS = 4;
	localparam int STEPS     = (KEY_W + 1) / STEP_BITS;
	localparam int CNT_W     = $clog2(STEPS);

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [KEY_W:0]          key_sh_q;
	logic [BUCKET_W-1:0]     rem_q;
	logic [BUCKET_W-1:0]     rem_next;
	logic [CFG_W-1:0]        n_norm;
	logic [OP_W-1:0]         op_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] value_q;

	always_comb begin
		if (bucket_count == '0) begin
			n_norm = CFG_W'(1);
		end else if (bucket_count > CFG_W'(MAX_BUCKETS)) begin
			n_norm = CFG_W'(MAX_BUCKETS);
		end else begin
			n_norm = bucket_count;
		end
	end

	always_comb begin
		logic [BUCKET_W:0] t;
		logic [BUCKET_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, key_sh_q[KEY_W-i]};
			if (CFG_W'(t) >= n_norm) begin
				t = t - (BUCKET_W+1)'(n_norm);
			end
			r = t[BUCKET_W-1:0];
		end
		rem_next = r;
	end

	assign full   = (state_q != FR_IDLE);
	assign q_push = (state_q == FR_PUSH) && !q_full;
	assign q_req  = '{op: op_q, key: key_q, value: value_q, bucket: rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				FR_IDLE: begin
					if (push) begin
						state_q <= FR_DIV;
						cnt_q   <= '0;
					end
				end
				FR_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						state_q <= FR_PUSH;
					end
				end
				FR_PUSH: begin
					if (!q_full) begin
						state_q <= FR_IDLE;
					end
				end
				default: state_q <= FR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && push) begin
			op_q     <= operation;
			key_q    <= key;
			value_q  <= value;
			key_sh_q <= {1'b0, key};
			rem_q    <= '0;
		end else if (state_q == FR_DIV) begin
			key_sh_q <= key_sh_q << STEP_BITS;
			rem_q    <= rem_next;
		end
	end
endmodule

// ===== design/cht_req_queue.sv =====
// Two-entry queue of classified requests between front and back ends.
`timescale 1ns / 1ps
module cht_req_queue import cht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t wr_req,
	input  logic wr_push,
	output logic wr_full,
	output req_t rd_req,
	input  logic rd_pop,
	output logic rd_empty
);
	req_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign wr_full  = (count_q == 2'd2);
	assign rd_empty = (count_q == 2'd0);
	assign rd_req   = entry_q[rd_ptr_q];
	assign do_push  = wr_push && !wr_full;
	assign do_pop   = rd_pop && !rd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_req;
		end
	end
endmodule

// ===== design/cht_back.sv =====
// Back end: bucket read-modify-write on the slot memories and result register.
`timescale 1ns / 1ps
module cht_back import cht_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  req_t                    q_req,
	output logic                    q_pop,
	input  logic                    q_empty,
	input  logic                    pop,
	output logic                    empty,
	output logic                    found,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    bucket_full
);
	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_EVAL = 1'b1;

	logic                              state_q;
	req_t                              cur_q;
	logic                              res_valid_q;
	logic [WAYS-1:0]                   valid_q [MAX_BUCKETS];
	logic [WAYS-1:0][KEY_W-1:0]        key_mem [MAX_BUCKETS];
	logic [WAYS-1:0][VAL_W-1:0]        val_mem [MAX_BUCKETS];
	logic [WAYS-1:0][KEY_W-1:0]        key_row_q;
	logic [WAYS-1:0][VAL_W-1:0]        val_row_q;
	logic [WAYS-1:0][KEY_W-1:0]        key_new;
	logic [WAYS-1:0][VAL_W-1:0]        val_new;
	logic [WAYS-1:0]                   row_valid;
	logic                              start;
	logic                              eval;
	logic                              hit;
	logic                              free_any;
	logic [WAY_W-1:0]                  hit_way;
	logic [WAY_W-1:0]                  free_way;
	logic [WAY_W-1:0]                  wsel;
	logic                              mem_we;
	logic                              is_get;
	logic                              is_put;
	logic                              is_remove;

	assign start     = (state_q == BK_IDLE) && !q_empty && !res_valid_q;
	assign q_pop     = start;
	assign eval      = (state_q == BK_EVAL);
	assign row_valid = valid_q[cur_q.bucket];
	assign is_get    = (cur_q.op == OP_GET);
	assign is_put    = (cur_q.op == OP_PUT);
	assign is_remove = (cur_q.op == OP_REMOVE);
	assign empty     = !res_valid_q;

	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free_any = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_valid[w]) begin
				if (key_row_q[w] == cur_q.key) begin
					hit     = 1'b1;
					hit_way = WAY_W'(w);
				end
			end else begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		wsel          = hit ? hit_way : free_way;
		key_new       = key_row_q;
		val_new       = val_row_q;
		key_new[wsel] = cur_q.key;
		val_new[wsel] = cur_q.value;
		mem_we        = eval && is_put && (hit || free_any);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_row_q <= key_mem[q_req.bucket];
			val_row_q <= val_mem[q_req.bucket];
		end
		if (mem_we) begin
			key_mem[cur_q.bucket] <= key_new;
			val_mem[cur_q.bucket] <= val_new;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= q_req;
		end
		if (eval) begin
			found       <= hit && (is_get || is_put || is_remove);
			read_value  <= (is_get && hit) ? signed'(val_row_q[hit_way]) : MISS_VALUE;
			bucket_full <= is_put && !hit && !free_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
			for (int b = 0; b < MAX_BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (start) begin
						state_q <= BK_EVAL;
					end
				end
				BK_EVAL: begin
					state_q <= BK_IDLE;
				end
				default: state_q <= BK_IDLE;
			endcase
			if (eval) begin
				res_valid_q <= 1'b1;
				if (mem_we && !hit) begin
					valid_q[cur_q.bucket][free_way] <= 1'b1;
				end
				if (is_remove && hit) begin
					valid_q[cur_q.bucket][hit_way] <= 1'b0;
				end
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== design/chained_hash_table_top.sv =====
// Top level of the chained hash table: configuration register and unit wiring.
//
// Usage:
//   Requests enter through push/full: operation (get, put, remove), key and
//   value are taken at a rising edge with push high and full low.
//   Results leave through empty/pop: found, read_value and bucket_full show
//   the oldest result while empty is low and are taken with pop high.
//   cfg_write loads cfg_data into the bucket count; write it only when idle.
// Timing:
//   The front end computes the modulo 4 key bits per cycle and then hands
//   the request to the queue; full drops on the cycle after the hand-off, so
//   a new request is taken only once the last one has gone into the queue.
//   The back end reads a bucket row when it starts a request and writes the
//   row back in its evaluate state for a put.
// Reset:
//   arst_n clears all slot valid bits at once and sets the bucket count to 7.
// Stalls:
//   If pop stays low, one result is held, up to two requests wait in the
//   queue, a third waits in the front end, and full stays high until
//   results are taken.
`timescale 1ns / 1ps
module chained_hash_table_top import cht_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [OP_W-1:0]         operation,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    pop,
	output logic                    empty,
	output logic                    found,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    bucket_full,
	input  logic                    cfg_write,
	input  logic [CFG_W-1:0]        cfg_data
);
	logic [CFG_W-1:0] bucket_count_q;
	req_t             front_req;
	req_t             back_req;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_W'(7);
		end else if (cfg_write) begin
			bucket_count_q <= cfg_data;
		end
	end

	cht_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.key          (key),
		.value        (value),
		.bucket_count (bucket_count_q),
		.q_req        (front_req),
		.q_push       (q_push),
		.q_full       (q_full)
	);

	cht_req_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_req   (front_req),
		.wr_push  (q_push),
		.wr_full  (q_full),
		.rd_req   (back_req),
		.rd_pop   (q_pop),
		.rd_empty (q_empty)
	);

	cht_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_req       (back_req),
		.q_pop       (q_pop),
		.q_empty     (q_empty),
		.pop         (pop),
		.empty       (empty),
		.found       (found),
		.read_value  (read_value),
		.bucket_full (bucket_full)
	);
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the chained hash table: directed and random get/put/remove traffic.
`timescale 1ns / 1ps
module tb_top;
	import cht_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SLOTS          = MAX_BUCKETS * WAYS;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 138;

	typedef enum {REQ_ITEM, CFG_ITEM, DRAIN_ITEM, HOLD_ITEM} backlog_kind_t;

	typedef struct {
		backlog_kind_t           kind;
		logic [OP_W-1:0]         op;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] val;
		logic [CFG_W-1:0]        cfg;
		int                      gap;
		bit                      calm;
	} backlog_t;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic [KEY_W-1:0]        key;
		logic                    found;
		logic signed [VAL_W-1:0] rd;
		logic                    full;
	} answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic                    full;
	logic [OP_W-1:0]         operation = OP_GET;
	logic [KEY_W-1:0]        key = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    pop = 1'b0;
	logic                    empty;
	logic                    found;
	logic signed [VAL_W-1:0] read_value;
	logic                    bucket_full;
	logic                    cfg_write = 1'b0;
	logic [CFG_W-1:0]        cfg_data = '0;

	backlog_t request_backlog[$];
	answer_t  table_answers[$];

	logic                    mirror_valid[SLOTS];
	logic [KEY_W-1:0]        mirror_key[SLOTS];
	logic signed [VAL_W-1:0] mirror_value[SLOTS];
	logic [CFG_W-1:0]        mirror_buckets = 7'd7;

	int errors = 0;
	int gap_left = 0;
	int hold_left = 0;
	int idle_left = 0;
	int quiet_cycles = 0;
	bit hold_req = 0;
	bit rx_calm = 0;

	chained_hash_table_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.pop        (pop),
		.empty      (empty),
		.found      (found),
		.read_value (read_value),
		.bucket_full(bucket_full),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic answer_t lookup_and_update(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic signed [VAL_W-1:0] v);
		answer_t a;
		int n;
		int base;
		int hit;
		int free_slot;
		a.op = op;
		a.key = k;
		a.found = 1'b0;
		a.rd = MISS_VALUE;
		a.full = 1'b0;
		if (op == OP_UNUSED)
			return a;
		n = int'(mirror_buckets);
		if (n == 0)
			n = 1;
		if (n > MAX_BUCKETS)
			n = MAX_BUCKETS;
		base = int'(k % n) * WAYS;
		hit = -1;
		free_slot = -1;
		for (int s = 0; s < WAYS; s++) begin
			if (mirror_valid[base + s]) begin
				if (hit < 0 && mirror_key[base + s] == k)
					hit = base + s;
			end else if (free_slot < 0) begin
				free_slot = base + s;
			end
		end
		a.found = (hit >= 0);
		case (op)
			OP_GET: begin
				if (hit >= 0)
					a.rd = mirror_value[hit];
			end
			OP_PUT: begin
				if (hit >= 0) begin
					mirror_value[hit] = v;
				end else if (free_slot >= 0) begin
					mirror_valid[free_slot] = 1'b1;
					mirror_key[free_slot] = k;
					mirror_value[free_slot] = v;
				end else begin
					a.full = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (hit >= 0)
					mirror_valid[hit] = 1'b0;
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic signed [VAL_W-1:0] v,
			int gap, bit calm);
		backlog_t b;
		b.kind = REQ_ITEM;
		b.op = op;
		b.key = k;
		b.val = v;
		b.cfg = '0;
		b.gap = gap;
		b.calm = calm;
		request_backlog.push_back(b);
	endtask

	task automatic add_ctl(backlog_kind_t kind, logic [CFG_W-1:0] cfg);
		backlog_t b;
		b.kind = kind;
		b.op = OP_GET;
		b.key = '0;
		b.val = '0;
		b.cfg = cfg;
		b.gap = 0;
		b.calm = 1'b0;
		request_backlog.push_back(b);
	endtask

	task automatic random_phase(logic [CFG_W-1:0] cfg, int hold_at, bit calm);
		logic [KEY_W-1:0]        pool[12];
		logic [OP_W-1:0]         op;
		logic [KEY_W-1:0]        k;
		logic signed [VAL_W-1:0] v;
		int                      gap;
		int                      r;
		add_ctl(DRAIN_ITEM, '0);
		add_ctl(CFG_ITEM, cfg);
		foreach (pool[i])
			pool[i] = ($urandom_range(0, 2) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 300));
		pool[11] = $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 40) ? OP_GET : (r < 80) ? OP_PUT : (r < 97) ? OP_REMOVE : OP_UNUSED;
			k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : pool[$urandom_range(0, 11)];
			if ($urandom_range(0, 15) == 0)
				v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			else
				v = $urandom;
			gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
			if (i >= hold_at && i < hold_at + 24)
				gap = 0;
			if (i == hold_at)
				add_ctl(HOLD_ITEM, '0);
			add_req(op, k, v, gap, calm);
		end
		foreach (pool[i])
			add_req(OP_REMOVE, pool[i], $urandom, 0, calm);
	endtask

	always @(posedge clk) begin
		backlog_t head;
		logic     nxt_push;
		logic     nxt_cfg;
		nxt_push = push;
		nxt_cfg = 1'b0;
		if (!arst_n) begin
			push <= 1'b0;
			cfg_write <= 1'b0;
		end else begin
			if (push && !full) begin
				table_answers.push_back(lookup_and_update(operation, key, value));
				nxt_push = 1'b0;
			end
			if (!nxt_push) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_backlog.size() > 0) begin
					head = request_backlog[0];
					if (head.gap > 0) begin
						gap_left = head.gap - 1;
						request_backlog[0].gap = 0;
					end else begin
						case (head.kind)
							REQ_ITEM: begin
								operation <= head.op;
								key <= head.key;
								value <= head.val;
								nxt_push = 1'b1;
								rx_calm = head.calm;
								void'(request_backlog.pop_front());
							end
							CFG_ITEM: begin
								if (table_answers.size() == 0 && !cfg_write) begin
									cfg_data <= head.cfg;
									nxt_cfg = 1'b1;
									mirror_buckets = head.cfg;
									void'(request_backlog.pop_front());
								end
							end
							DRAIN_ITEM: begin
								if (table_answers.size() == 0)
									void'(request_backlog.pop_front());
							end
							HOLD_ITEM: begin
								hold_req = 1'b1;
								void'(request_backlog.pop_front());
							end
						endcase
					end
				end
			end
			push <= nxt_push;
			cfg_write <= nxt_cfg;
		end
	end

	always @(posedge clk) begin
		answer_t want;
		logic    nxt_pop;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (table_answers.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: found %0b read_value %0d bucket_full %0b",
							found, read_value, bucket_full);
				end else begin
					want = table_answers.pop_front();
					if (found !== want.found || read_value !== want.rd ||
							bucket_full !== want.full) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch op %0d key %0d: found %0b/%0b ",
								"read_value %0d/%0d bucket_full %0b/%0b (expected/actual)"},
								want.op, want.key, want.found, found, want.rd, read_value,
								want.full, bucket_full);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_pop = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				nxt_pop = 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				nxt_pop = 1'b0;
			end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
				idle_left = $urandom_range(0, 3);
				nxt_pop = 1'b0;
			end else begin
				nxt_pop = 1'b1;
			end
			pop <= nxt_pop;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_write)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		foreach (mirror_valid[i]) begin
			mirror_valid[i] = 1'b0;
			mirror_key[i] = '0;
			mirror_value[i] = '0;
		end

		add_req(OP_GET, 31'd0, 32'sd0, 0, 0);
		add_req(OP_PUT, 31'd0, 32'sh7FFF_FFFF, 0, 0);
		add_req(OP_PUT, 31'd7, 32'sh8000_0000, 0, 0);
		add_req(OP_PUT, 31'd14, 32'sd0, 0, 0);
		add_req(OP_PUT, 31'd21, -32'sd1, 0, 0);
		add_req(OP_PUT, 31'd28, 32'sd1, 0, 0);
		add_req(OP_GET, 31'd0, 32'sd0, 0, 0);
		add_req(OP_PUT, 31'd0, 32'sd5, 0, 0);
		add_req(OP_GET, 31'd28, 32'sd0, 0, 0);
		add_req(OP_REMOVE, 31'd7, 32'sd0, 0, 0);
		add_req(OP_REMOVE, 31'd7, 32'sd0, 0, 0);
		add_req(OP_PUT, 31'd28, 32'sh5555_5555, 0, 0);
		add_req(OP_GET, 31'd28, 32'sd0, 0, 0);
		add_req(OP_GET, 31'h7FFF_FFFF, 32'sd0, 0, 0);
		add_req(OP_UNUSED, 31'h2AAA_AAAA, 32'shAAAA_AAAA, 0, 0);
		add_ctl(DRAIN_ITEM, '0);
		add_ctl(CFG_ITEM, 7'd5);
		add_req(OP_GET, 31'd21, 32'sd0, 0, 0);
		add_req(OP_GET, 31'd0, 32'sd0, 0, 0);
		add_ctl(DRAIN_ITEM, '0);
		add_ctl(CFG_ITEM, 7'd0);
		add_req(OP_PUT, 31'd3, 32'sd9, 0, 0);
		add_ctl(DRAIN_ITEM, '0);
		add_ctl(CFG_ITEM, 7'd127);
		add_req(OP_PUT, 31'h7FFF_FFFF, 32'sh0000_1234, 0, 0);
		add_req(OP_GET, 31'h7FFF_FFFF, 32'sd0, 0, 0);
		add_req(OP_REMOVE, 31'h7FFF_FFFF, 32'sd0, 0, 0);
		add_ctl(DRAIN_ITEM, '0);
		add_ctl(CFG_ITEM, 7'd7);
		add_req(OP_REMOVE, 31'd0, 32'sd0, 0, 0);
		add_req(OP_REMOVE, 31'd14, 32'sd0, 0, 0);
		add_req(OP_REMOVE, 31'd21, 32'sd0, 0, 0);
		add_req(OP_REMOVE, 31'd28, 32'sd0, 0, 0);

		random_phase(7'd1, -1, 0);
		random_phase(7'd64, -1, 0);
		random_phase(7'd2, -1, 0);
		random_phase(7'd127, 40, 0);
		random_phase(7'd0, -1, 0);
		random_phase(7'd13, -1, 1);
		random_phase(7'd65, -1, 0);
		random_phase(7'd3, -1, 0);
		random_phase(CFG_W'($urandom_range(0, 127)), -1, 0);
		random_phase(CFG_W'($urandom_range(0, 127)), -1, 0);
		random_phase(CFG_W'($urandom_range(1, 16)), -1, 0);
		random_phase(CFG_W'($urandom_range(0, 127)), -1, 1);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_backlog.size() > 0 || push)
			@(posedge clk);
		while (table_answers.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
